// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the windowed average scaler.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/was_pkg.sv =====
// Shared constants and types of the windowed average scaler.
// No dependencies.
package was_pkg;

    localparam int WINDOW    = 50;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 22;
    localparam int HALF_W    = 14;
    localparam int POS_W     = 8;
    // Serial divider: dividend covers |sum| and the scaled offset (15 bits times 255).
    localparam int DIV_W     = 23;
    localparam int DEN_W     = HALF_W + 1;
    localparam int ADDR_W    = 3;

    localparam logic ACT_PUSH    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic REG_CENTRE = 1'b0;
    localparam logic REG_HALF   = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] CENTRE_RST = -16'sd18;
    localparam logic [HALF_W-1:0]          HALF_RST   = 14'd82;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/was_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module was_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 50
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/was_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on was_pkg.
module was_div
    import was_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;

    logic [DEN_W:0]    n_trial;
    logic              n_qbit;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        n_trial = {r_rem, r_num[DIV_W-1]};
        n_qbit  = (n_trial >= {1'b0, r_den});
        n_rem   = n_qbit ? DEN_W'(n_trial - {1'b0, r_den}) : n_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_num  <= {r_num[DIV_W-2:0], n_qbit};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

// ===== rtl/windowed_average_axis_scaler_core.sv =====
// Push transfer: ring read (S_READ), then update (S_UPD), then input ready again.
// Request transfer: mean division (S_AVGW), position division (S_POSW, skipped
// if half_span is 0), then S_OUT: result valid and input ready, later if one waits.
// Reset (synchronous, active low): ring reads as zero through per-slot valid bits,
// sum, count and slot cleared, axis_centre = -18, half_span = 82. No clearing pass.
// Depends on was_pkg, was_ram, was_div (one shared serial divider), assert_macros.svh.
`include "assert_macros.svh"

module windowed_average_axis_scaler_core
    import was_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // stream in
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [15:0]         i_s_tdata,   // [15:0] sample
    input  logic                i_s_tuser,   // [0] action
    // stream out
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [23:0]         o_m_tdata,   // [15:0] average, [23:16] position
    // config
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready
);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_UPD, S_AVG, S_AVGW, S_SCALE, S_POSW, S_OUT
    } t_state;

    t_state                      r_state;
    logic signed [SAMPLE_W-1:0]  r_centre;
    logic [HALF_W-1:0]           r_half;
    logic [WINDOW-1:0]           r_valid;
    logic [SLOT_W-1:0]           r_slot;
    logic [CNT_W-1:0]            r_count;
    logic signed [SUM_W-1:0]     r_sum;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic signed [SAMPLE_W-1:0]  r_avg;
    logic [POS_W-1:0]            r_pos;
    logic                        r_out_valid;
    logic [23:0]                 r_out_data;

    logic [SAMPLE_W-1:0]         ram_rdata;
    logic                        ram_we;
    t_div_req                    div_req;
    t_div_rsp                    div_rsp;

    logic                        cfg_write;
    logic                        in_xfer;
    logic signed [SAMPLE_W-1:0]  n_old;
    logic signed [SUM_W-1:0]     n_sum;
    logic [SUM_W-1:0]            n_mag;
    logic signed [SAMPLE_W-1:0]  n_avg;
    logic signed [17:0]          n_lo;
    logic signed [17:0]          n_hi;
    logic signed [17:0]          n_x;
    logic [17:0]                 n_off;
    logic [DIV_W-1:0]            n_prod;

    assign cfg_write  = i_psel && i_penable && i_pwrite;
    assign o_pready   = 1'b1;
    assign o_prdata   = (i_paddr[2] == REG_HALF) ? {18'd0, r_half}
                                                 : {{16{r_centre[15]}}, r_centre};
    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign ram_we = (r_state == S_UPD);

    was_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(WINDOW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_slot),
        .i_wdata(r_sample),
        .i_raddr(r_slot),
        .o_rdata(ram_rdata)
    );

    was_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_comb begin
        // never-written slots read as zero
        n_old = r_valid[r_slot] ? $signed(ram_rdata) : '0;
        n_sum = r_sum - SUM_W'(n_old) + SUM_W'(r_sample);
        n_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        n_avg = r_sum[SUM_W-1] ? SAMPLE_W'(-div_rsp.quot) : SAMPLE_W'(div_rsp.quot);

        // clamp bounds at full width, then offset * 255 as shift and subtract
        n_lo   = 18'(r_centre) - $signed({4'd0, r_half});
        n_hi   = 18'(r_centre) + $signed({4'd0, r_half});
        n_x    = 18'(r_avg);
        if (n_x < n_lo) begin
            n_x = n_lo;
        end
        if (n_x > n_hi) begin
            n_x = n_hi;
        end
        n_off  = 18'(n_x - n_lo);
        n_prod = {n_off[14:0], 8'd0} - DIV_W'(n_off[14:0]);

        div_req.start = 1'b0;
        div_req.num   = {1'b0, n_mag};
        div_req.den   = (r_count == '0) ? DEN_W'(1) : DEN_W'(r_count);
        if (r_state == S_AVG) begin
            div_req.start = 1'b1;
        end else if (r_state == S_SCALE) begin
            div_req.start = (r_half != '0);
            div_req.num   = n_prod;
            div_req.den   = {r_half, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_centre    <= CENTRE_RST;
            r_half      <= HALF_RST;
            r_valid     <= '0;
            r_slot      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_write) begin
                if (i_paddr[2] == REG_CENTRE) begin
                    r_centre <= $signed(i_pwdata[15:0]);
                end else begin
                    r_half <= i_pwdata[HALF_W-1:0];
                end
            end

            // S_OUT reloads the output stage itself
            if (r_out_valid && i_m_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_sample <= $signed(i_s_tdata);
                        r_state  <= (i_s_tuser == ACT_PUSH) ? S_READ : S_AVG;
                    end
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_sum          <= n_sum;
                    r_valid[r_slot] <= 1'b1;
                    r_slot  <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    if (r_count != CNT_W'(WINDOW)) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_AVG: begin
                    r_state <= S_AVGW;
                end
                S_AVGW: begin
                    if (div_rsp.done) begin
                        r_avg   <= n_avg;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (r_half == '0) begin
                        r_pos   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_POSW;
                    end
                end
                S_POSW: begin
                    if (div_rsp.done) begin
                        r_pos   <= div_rsp.quot[POS_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_pos, r_avg};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(WINDOW))
    `ASSERT_NEVER(a_slot_range, i_clk, i_rst_n, r_slot > SLOT_W'(WINDOW - 1))
    `ASSERT_SYNC(a_result_from_out, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
    `ASSERT_SYNC(a_done_in_wait, i_clk, i_rst_n,
        div_rsp.done |-> (r_state == S_AVGW || r_state == S_POSW))

endmodule

// ===== bench/average_checker.sv =====
// Checker for windowed_average_axis_scaler_core: follows APB writes and input transfers,
// predicts the average/position of every request and compares the output transfers.
// Depends on was_pkg.
module average_checker
    import was_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [15:0]       i_s_tdata,   // [15:0] sample
    input  logic              i_s_tuser,   // [0] action
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [23:0]       i_m_tdata,   // [15:0] average, [23:16] position
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output int                o_mismatches,
    output int                o_outstanding
);
    typedef struct {
        logic signed [SAMPLE_W-1:0] average;
        logic [POS_W-1:0]           position;
    } t_reading;

    logic signed [SAMPLE_W-1:0] ring [WINDOW];
    int                         slot;
    int                         sum;
    int                         fill;
    logic signed [SAMPLE_W-1:0] centre;
    logic [HALF_W-1:0]          half;
    t_reading                   expected_readings [$];

    // Truncating mean over the filled part of the ring, clamped and mapped onto 0..255.
    function automatic t_reading predict_reading();
        int       divisor;
        int       mean;
        int       lo;
        int       hi;
        int       clamped;
        t_reading r;
        divisor = (fill == 0) ? 1 : fill;
        mean    = sum / divisor;
        lo      = int'(centre) - int'(half);
        hi      = int'(centre) + int'(half);
        clamped = (mean < lo) ? lo : ((mean > hi) ? hi : mean);
        r.average = mean[SAMPLE_W-1:0];
        if (half == 0) begin
            r.position = '0;
        end else begin
            r.position = POS_W'(((clamped - lo) * 255) / (2 * int'(half)));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reading want;
        if (!i_rst_n) begin
            foreach (ring[k]) ring[k] = '0;
            slot   = 0;
            sum    = 0;
            fill   = 0;
            centre = CENTRE_RST;
            half   = HALF_RST;
            expected_readings.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_CENTRE, 2'b00}) begin
                    centre = i_pwdata[SAMPLE_W-1:0];
                end else if (i_paddr == {REG_HALF, 2'b00}) begin
                    half = i_pwdata[HALF_W-1:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == ACT_PUSH) begin
                    sum = sum - int'(ring[slot]) + int'($signed(i_s_tdata));
                    ring[slot] = i_s_tdata;
                    slot = (slot == WINDOW - 1) ? 0 : slot + 1;
                    if (fill < WINDOW) fill++;
                end else begin
                    expected_readings.push_back(predict_reading());
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_readings.size() == 0) begin
                    $error("result transfer with no request pending: tdata=%h", i_m_tdata);
                    o_mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (i_m_tdata[15:0] !== want.average) begin
                        $error("average: expected %0d, actual %0d",
                               want.average, $signed(i_m_tdata[15:0]));
                        o_mismatches++;
                    end
                    if (i_m_tdata[23:16] !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, i_m_tdata[23:16]);
                        o_mismatches++;
                    end
                end
            end
        end
        o_outstanding = expected_readings.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench for windowed_average_axis_scaler_core: clock, reset, APB setup,
// sample/request stimulus and verdict. Depends on was_pkg, the core and average_checker.
module testbench;
    import was_pkg::*;

    localparam int DRAIN_CYCLES    = 60;
    localparam int PHASE_ITEMS     = 215;
    localparam int PHASES          = 8;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;
    logic              s_tuser   = ACT_PUSH;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    int mismatches;
    int outstanding;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int cur_centre      = -18;
    int cur_half        = 82;

    always #10 clk = ~clk;

    windowed_average_axis_scaler_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    average_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #20_000_000;
        $display("** windowed_average_axis_scaler_core: FAILED **");
        $finish;
    end

    function automatic logic [15:0] clip16(input int v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // Called and returns at a falling edge.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input int centre, input int half);
        cur_centre = centre;
        cur_half   = half;
        apb_write({REG_CENTRE, 2'b00}, {16'h0000, centre[15:0]});
        apb_write({REG_HALF, 2'b00}, {18'h0, half[HALF_W-1:0]});
    endtask

    task automatic send_item(input logic act, input logic [15:0] smp);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic push_sample(input logic [15:0] smp);
        send_item(ACT_PUSH, smp);
    endtask

    // The sample field of a request is ignored, so it carries noise.
    task automatic request_reading();
        send_item(ACT_REQUEST, 16'($urandom));
    endtask

    // Block goes idle: all results back, then room for a trailing push to finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        int phase;
        int sent;
        int pushes;
        int requests;
        int style;
        int level;
        int spread;
        int offs;
        logic [15:0] smp;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty window, full-scale extremes, truncation of a negative mean.
        request_reading();
        push_sample(16'h7fff);
        request_reading();
        push_sample(16'h8000);
        request_reading();
        push_sample(16'h8000);
        request_reading();
        push_sample(16'h0000);
        push_sample(16'hffff);
        request_reading();
        push_sample(16'hffee);
        push_sample(16'h0040);
        push_sample(16'hff9c);
        request_reading();
        request_reading();

        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: set_window(0, 1);
                1: set_window(32767, 16383);    // window runs past the top of the range
                2: set_window(-32768, 16383);   // and past the bottom
                3: set_window(100, 0);          // collapsed window
                4: set_window(-100, 64);
                5: set_window($signed(16'($urandom)), $urandom_range(0, 16383));
                6: set_window(0, 16383);
                default: set_window(-18, 82);
            endcase
            case (phase % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 82; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 82; end
                default: begin sender_idle_pct = 26; stall_pct = 26; end
            endcase

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pushes   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 60);
                requests = $urandom_range(1, 2);
                style    = $urandom_range(7);
                spread   = (1 << $urandom_range(0, 16)) - 1;
                if (style < 4) begin
                    // level near the clamp window so clamping and scaling both see use
                    offs  = int'($urandom_range(4 * cur_half + 8)) - (2 * cur_half + 4);
                    level = cur_centre + offs;
                    spread = spread >> 6;
                end else if (style < 6) begin
                    level = $urandom_range(1) ? 32767 : -32768;
                end else begin
                    level = $signed(16'($urandom));
                end
                repeat (pushes) begin
                    if (style == 7) begin
                        smp = 16'($urandom);
                    end else begin
                        smp = clip16(level + int'($urandom_range(2 * spread)) - spread);
                    end
                    push_sample(smp);
                end
                repeat (requests) request_reading();
                sent += pushes + requests;
                // hold off mid-phase once until the pipeline has emptied
                if (phase == 0 && sent >= PHASE_ITEMS / 2 && sent - pushes - requests
                        < PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    while (outstanding != 0) @(negedge clk);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** windowed_average_axis_scaler_core: PASSED **");
        end else begin
            $display("** windowed_average_axis_scaler_core: FAILED **");
        end
        $finish;
    end

endmodule
